FILE: design/sor_pkg.sv
package sor_pkg;

  // relaxation factor 1.0 in Q2.14
  localparam logic [15:0]        RELAX_RESET = 16'd16384;
  localparam logic signed [16:0] ONE_Q14     = 17'sd16384;

  // divide by 6 * 16384 = 3 * 2^15, half of it for round to nearest
  localparam logic [53:0] ROUND_HALF = 54'd49152;
  localparam int          DIV_SHIFT  = 15;

  // largest useful shifted magnitude, quotient 2^31 saturates either way
  localparam logic [32:0] T_MAX = 33'h1_8000_0000;

  // reciprocal of 3 scaled by 2^20, exact for operands below 2^19
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;

  // stage 1: gathered stencil sum
  typedef struct packed {
    logic signed [34:0] sum;
    logic signed [34:0] six_prev;
    logic signed [31:0] prev;
    logic signed [31:0] center;
    logic               bypass;
  } sor_gather_t;

  // stage 2: weighted products
  typedef struct packed {
    logic signed [51:0] p_stencil;
    logic signed [51:0] p_prev;
    logic signed [31:0] prev;
    logic signed [31:0] center;
    logic               bypass;
  } sor_prod_t;

  // stage 3: blended numerator
  typedef struct packed {
    logic signed [52:0] n;
    logic signed [31:0] prev;
    logic signed [31:0] center;
    logic               bypass;
  } sor_acc_t;

  // stage 4: rounded magnitude shifted by 2^15, still to divide by 3
  typedef struct packed {
    logic [32:0]        t;
    logic               neg;
    logic signed [31:0] prev;
    logic signed [31:0] center;
    logic               bypass;
  } sor_rnd_t;

  // stage 5: upper quotient digits and partial remainder
  typedef struct packed {
    logic [14:0]        qh;
    logic [18:0]        v2;
    logic               neg;
    logic signed [31:0] prev;
    logic signed [31:0] center;
    logic               bypass;
  } sor_hi_t;

  // stage 6: final value and change magnitude
  typedef struct packed {
    logic signed [31:0] result;
    logic [31:0]        mag;
  } sor_fin_t;

  function automatic logic [17:0] div3(input logic [18:0] v);
    logic [37:0] prod;
    prod = 38'(v) * 38'(DIV3_RECIP);
    return prod[37:20];
  endfunction

endpackage

FILE: design/sor_gather.sv
module sor_gather
  import sor_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] center_value,
  input  logic signed [31:0] previous_value,
  input  logic signed [31:0] x_minus,
  input  logic signed [31:0] x_plus,
  input  logic signed [31:0] y_minus,
  input  logic signed [31:0] y_plus,
  input  logic signed [31:0] z_minus,
  input  logic signed [31:0] z_plus,
  input  logic [5:0]         neighbour_active,
  input  logic               node_active,
  input  logic               node_fixed,
  output sor_gather_t        gather
);

  logic signed [31:0] sel [6];
  sor_gather_t        gather_next;

  // an inactive neighbour mirrors the opposite one on its axis
  always_comb begin
    sel[0] = neighbour_active[0] ? x_minus : x_plus;
    sel[1] = neighbour_active[1] ? x_plus  : x_minus;
    sel[2] = neighbour_active[2] ? y_minus : y_plus;
    sel[3] = neighbour_active[3] ? y_plus  : y_minus;
    sel[4] = neighbour_active[4] ? z_minus : z_plus;
    sel[5] = neighbour_active[5] ? z_plus  : z_minus;
    gather_next.sum = 35'(sel[0]) + 35'(sel[1]) + 35'(sel[2])
                    + 35'(sel[3]) + 35'(sel[4]) + 35'(sel[5]);
    gather_next.six_prev = (35'(previous_value) <<< 2) + (35'(previous_value) <<< 1);
    gather_next.prev     = previous_value;
    gather_next.center   = center_value;
    gather_next.bypass   = !node_active || node_fixed;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gather <= gather_next;
    end
  end

endmodule

FILE: design/sor_blend.sv
module sor_blend
  import sor_pkg::*;
(
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [15:0] relaxation,
  input  sor_gather_t gather,
  output sor_acc_t    acc
);

  logic signed [16:0] w_s;
  logic signed [16:0] w_c;
  sor_prod_t          prod;

  // weight on the stencil and its complement on the previous value
  assign w_s = $signed({1'b0, relaxation});
  assign w_c = ONE_Q14 - w_s;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod.p_stencil <= 52'(w_s) * 52'(gather.sum);
      prod.p_prev    <= 52'(w_c) * 52'(gather.six_prev);
      prod.prev      <= gather.prev;
      prod.center    <= gather.center;
      prod.bypass    <= gather.bypass;
    end
    if (en[1]) begin
      acc.n      <= 53'(prod.p_stencil) + 53'(prod.p_prev);
      acc.prev   <= prod.prev;
      acc.center <= prod.center;
      acc.bypass <= prod.bypass;
    end
  end

endmodule

FILE: design/sor_round.sv
module sor_round
  import sor_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] en,
  input  sor_acc_t   acc,
  output sor_fin_t   fin
);

  logic [52:0]        mag;
  logic [53:0]        rounded;
  logic [38:0]        shifted;
  sor_rnd_t           rnd;
  logic [15:0]        th;
  logic [17:0]        qh_full;
  logic [15:0]        rem;
  sor_hi_t            hi;
  logic [17:0]        ql_full;
  logic [31:0]        q;
  logic signed [31:0] quot;
  logic signed [31:0] result;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;

  // magnitude plus half divisor, then the power of two part of the divisor
  always_comb begin
    mag     = acc.n[52] ? 53'(-acc.n) : 53'(acc.n);
    rounded = 54'(mag) + ROUND_HALF;
    shifted = rounded[53:DIV_SHIFT];
  end

  // divide by 3 in two digit groups, upper 16 bits first
  always_comb begin
    th      = rnd.t[32:17];
    qh_full = div3({3'b000, th});
    rem     = th - (16'(qh_full[14:0]) << 1) - 16'(qh_full[14:0]);
  end

  always_comb begin
    ql_full = div3(hi.v2);
    q       = {hi.qh, 17'b0} + 32'(ql_full[16:0]);
    if (hi.neg) begin
      quot = $signed(32'd0 - q);
    end else if (q > Q_POS_MAX) begin
      quot = $signed(Q_POS_MAX);
    end else begin
      quot = $signed(q);
    end
    result   = hi.bypass ? hi.center : quot;
    diff     = 33'(result) - 33'(hi.prev);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rnd.t      <= (shifted > 39'(T_MAX)) ? T_MAX : shifted[32:0];
      rnd.neg    <= acc.n[52];
      rnd.prev   <= acc.prev;
      rnd.center <= acc.center;
      rnd.bypass <= acc.bypass;
    end
    if (en[1]) begin
      hi.qh     <= qh_full[14:0];
      hi.v2     <= {rem[1:0], rnd.t[16:0]};
      hi.neg    <= rnd.neg;
      hi.prev   <= rnd.prev;
      hi.center <= rnd.center;
      hi.bypass <= rnd.bypass;
    end
    if (en[2]) begin
      fin.result <= result;
      fin.mag    <= diff_mag[31:0];
    end
  end

endmodule

FILE: design/sor_stencil_node_update.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | center_value .. z_plus, neighbour_active, flags
// output   | out_valid / out_ready| new_value, squared_change
// config   | cfg_we               | cfg_wdata (relaxation, Q2.14)
//
// seven register stages, one word in per cycle while out_ready does not stall the chain
// the stage chain: gather, two products, add, round,
// two divide-by-3 digit groups with saturation, then the squaring multiplier
// each stage holds its word while the next cannot move on, bubbles close up on a stall
// rst clears the stage valid bits and loads relaxation with 1.0
module sor_stencil_node_update
  import sor_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_value,
  input  logic signed [31:0] previous_value,
  input  logic signed [31:0] x_minus,
  input  logic signed [31:0] x_plus,
  input  logic signed [31:0] y_minus,
  input  logic signed [31:0] y_plus,
  input  logic signed [31:0] z_minus,
  input  logic signed [31:0] z_plus,
  input  logic [5:0]         neighbour_active,
  input  logic               node_active,
  input  logic               node_fixed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_value,
  output logic [63:0]        squared_change
);

  localparam int NSTAGE = 7;

  logic [15:0]       relaxation;
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;
  sor_gather_t       gather;
  sor_acc_t          acc;
  sor_fin_t          fin;

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      relaxation <= RELAX_RESET;
      vld        <= '0;
    end else begin
      if (cfg_we) begin
        relaxation <= cfg_wdata;
      end
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: neighbour selection and sum
  sor_gather u_gather (
    .clk              (clk),
    .en               (en[0]),
    .center_value     (center_value),
    .previous_value   (previous_value),
    .x_minus          (x_minus),
    .x_plus           (x_plus),
    .y_minus          (y_minus),
    .y_plus           (y_plus),
    .z_minus          (z_minus),
    .z_plus           (z_plus),
    .neighbour_active (neighbour_active),
    .node_active      (node_active),
    .node_fixed       (node_fixed),
    .gather           (gather)
  );

  // stages 2 and 3: relaxation products and their sum
  sor_blend u_blend (
    .clk        (clk),
    .en         (en[2:1]),
    .relaxation (relaxation),
    .gather     (gather),
    .acc        (acc)
  );

  // stages 4 to 6: rounding divide by 98304, saturation, change magnitude
  sor_round u_round (
    .clk (clk),
    .en  (en[5:3]),
    .acc (acc),
    .fin (fin)
  );

  // stage 7: output word, squared change fits 64 bits since |diff| < 2^32
  always_ff @(posedge clk) begin
    if (en[6]) begin
      new_value      <= fin.result;
      squared_change <= 64'(fin.mag) * 64'(fin.mag);
    end
  end

endmodule
